### src/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// shared types and constants for the line pixel stepper
// ---------------------------------------------------------------------------
package lps_pkg;

   localparam int CoordBits = 12;
   localparam int ErrBits   = CoordBits + 1;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic        [CoordBits-1:0] len_type;
   typedef logic        [ErrBits-1:0]   err_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MINOR_HOLD = 2'b00,
      MINOR_UP   = 2'b01,
      MINOR_DOWN = 2'b11
   } minor_dir_type;

   typedef struct packed {
      op_type    op;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_item_type;

   typedef struct packed {
      logic      pixel_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } rsp_item_type;

endpackage

### src/line_pixel_stepper_top.sv
// ---------------------------------------------------------------------------
// line_pixel_stepper_top
// an accepted item passes the input register, then the result register
// throughput: one item per cycle while the result side does not stall; the step is one add, one compare, one subtract
// req_stall rises only while both registers are full and rsp_stall is high
// reset (synchronous, active high) empties both registers and idles the stepper
// each item gives exactly one result; pixel fields are zero when no pixel
// ---------------------------------------------------------------------------
module line_pixel_stepper_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lps_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lps_pkg::rsp_item_type rsp_item
);
   import lps_pkg::*;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff,  s1_item_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff,  rsp_item_in;

   // stepper state
   logic          active_ff,     active_in;
   coord_type     cur_major_ff,  cur_major_in;
   coord_type     cur_minor_ff,  cur_minor_in;
   coord_type     stop_major_ff, stop_major_in;
   logic          major_dir_ff,  major_dir_in;
   minor_dir_type minor_dir_ff,  minor_dir_in;
   len_type       major_len_ff,  major_len_in;
   len_type       minor_len_ff,  minor_len_in;
   err_type       error_acc_ff,  error_acc_in;
   logic          y_major_ff,    y_major_in;

   logic          s1_advance;
   logic          is_start;
   err_type       diff_x, diff_y, neg_x, neg_y;
   len_type       len_x, len_y;
   logic          reject;
   logic          x_major;
   coord_type     ld_mi0, ld_mi1;

   logic          eff_active;
   coord_type     eff_major, eff_minor, eff_stop;
   logic          eff_major_dir;
   minor_dir_type eff_minor_dir;
   len_type       eff_major_len, eff_minor_len;
   err_type       eff_err;
   logic          eff_y_major;

   err_type       err_sum, err_thresh;
   logic          minor_step;
   coord_type     minor_inc;
   coord_type     next_major, next_minor;
   err_type       next_err;
   logic          last;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      is_start = (s1_item_ff.op == OP_START);

      // segment setup
      diff_x = {s1_item_ff.start_x[CoordBits-1], s1_item_ff.start_x}
             - {s1_item_ff.end_x[CoordBits-1], s1_item_ff.end_x};
      diff_y = {s1_item_ff.start_y[CoordBits-1], s1_item_ff.start_y}
             - {s1_item_ff.end_y[CoordBits-1], s1_item_ff.end_y};
      neg_x  = ErrBits'(0) - diff_x;
      neg_y  = ErrBits'(0) - diff_y;
      len_x  = diff_x[ErrBits-1] ? neg_x[CoordBits-1:0] : diff_x[CoordBits-1:0];
      len_y  = diff_y[ErrBits-1] ? neg_y[CoordBits-1:0] : diff_y[CoordBits-1:0];
      reject = (s1_item_ff.start_x[CoordBits-1] && s1_item_ff.end_x[CoordBits-1])
            || (len_x == '0 && len_y == '0);
      x_major = (len_x > len_y);

      if (is_start) begin
         eff_active = !reject;
         eff_err    = '0;
         if (x_major) begin
            eff_y_major   = 1'b0;
            eff_major     = s1_item_ff.start_x;
            eff_stop      = s1_item_ff.end_x;
            eff_major_dir = ($signed(s1_item_ff.end_x) < $signed(s1_item_ff.start_x));
            eff_major_len = len_x;
            eff_minor_len = len_y;
            ld_mi0        = s1_item_ff.start_y;
            ld_mi1        = s1_item_ff.end_y;
         end else begin
            eff_y_major   = 1'b1;
            eff_major     = s1_item_ff.start_y;
            eff_stop      = s1_item_ff.end_y;
            eff_major_dir = ($signed(s1_item_ff.end_y) < $signed(s1_item_ff.start_y));
            eff_major_len = len_y;
            eff_minor_len = len_x;
            ld_mi0        = s1_item_ff.start_x;
            ld_mi1        = s1_item_ff.end_x;
         end
         eff_minor = ld_mi0;
         if ($signed(ld_mi1) > $signed(ld_mi0)) begin
            eff_minor_dir = MINOR_UP;
         end else if ($signed(ld_mi1) < $signed(ld_mi0)) begin
            eff_minor_dir = MINOR_DOWN;
         end else begin
            eff_minor_dir = MINOR_HOLD;
         end
      end else begin
         eff_active    = active_ff;
         eff_err       = error_acc_ff;
         eff_y_major   = y_major_ff;
         eff_major     = cur_major_ff;
         eff_stop      = stop_major_ff;
         eff_major_dir = major_dir_ff;
         eff_major_len = major_len_ff;
         eff_minor_len = minor_len_ff;
         eff_minor     = cur_minor_ff;
         eff_minor_dir = minor_dir_ff;
         ld_mi0        = '0;
         ld_mi1        = '0;
      end

      // one pixel step
      err_sum    = eff_err + {1'b0, eff_minor_len} + ErrBits'(1);
      err_thresh = {1'b0, eff_major_len} + ErrBits'(1);
      minor_step = (err_sum >= err_thresh);
      case (eff_minor_dir)
         MINOR_UP:   minor_inc = CoordBits'(1);
         MINOR_DOWN: minor_inc = '1;
         default:    minor_inc = '0;
      endcase
      next_minor = minor_step ? eff_minor + minor_inc : eff_minor;
      next_err   = minor_step ? err_sum - err_thresh : err_sum;
      next_major = eff_major_dir ? eff_major - CoordBits'(1) : eff_major + CoordBits'(1);
      last       = (next_major == eff_stop);

      // result
      rsp_item_in.pixel_valid = eff_active;
      rsp_item_in.pixel_x     = '0;
      rsp_item_in.pixel_y     = '0;
      rsp_item_in.last_pixel  = 1'b0;
      if (eff_active) begin
         rsp_item_in.pixel_x    = eff_y_major ? eff_minor : eff_major;
         rsp_item_in.pixel_y    = eff_y_major ? eff_major : eff_minor;
         rsp_item_in.last_pixel = last;
      end

      // next state
      active_in     = active_ff;
      cur_major_in  = cur_major_ff;
      cur_minor_in  = cur_minor_ff;
      stop_major_in = stop_major_ff;
      major_dir_in  = major_dir_ff;
      minor_dir_in  = minor_dir_ff;
      major_len_in  = major_len_ff;
      minor_len_in  = minor_len_ff;
      error_acc_in  = error_acc_ff;
      y_major_in    = y_major_ff;
      if (s1_advance) begin
         if (eff_active) begin
            active_in     = !last;
            cur_major_in  = next_major;
            cur_minor_in  = next_minor;
            stop_major_in = eff_stop;
            major_dir_in  = eff_major_dir;
            minor_dir_in  = eff_minor_dir;
            major_len_in  = eff_major_len;
            minor_len_in  = eff_minor_len;
            error_acc_in  = next_err;
            y_major_in    = eff_y_major;
         end else if (is_start) begin
            active_in = 1'b0;
         end
      end

      // handshake registers
      s1_valid_in = s1_valid_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end
      s1_item_in = (req_valid && !req_stall) ? req_item : s1_item_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         cur_major_ff  <= '0;
         cur_minor_ff  <= '0;
         stop_major_ff <= '0;
         major_dir_ff  <= 1'b0;
         minor_dir_ff  <= MINOR_HOLD;
         major_len_ff  <= '0;
         minor_len_ff  <= '0;
         error_acc_ff  <= '0;
         y_major_ff    <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         active_ff     <= active_in;
         cur_major_ff  <= cur_major_in;
         cur_minor_ff  <= cur_minor_in;
         stop_major_ff <= stop_major_in;
         major_dir_ff  <= major_dir_in;
         minor_dir_ff  <= minor_dir_in;
         major_len_ff  <= major_len_in;
         minor_len_ff  <= minor_len_in;
         error_acc_ff  <= error_acc_in;
         y_major_ff    <= y_major_in;
      end
      s1_item_ff <= s1_item_in;
      if (s1_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // error stays below the wrap point while a segment runs
   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (error_acc_ff <= {1'b0, major_len_ff}))
      else $error("error accumulator out of range");

   // a result without a pixel carries zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.pixel_valid) |->
         (rsp_item_ff.pixel_x == '0 && rsp_item_ff.pixel_y == '0
          && !rsp_item_ff.last_pixel))
      else $error("empty result has nonzero fields");

   // the last pixel idles the stepper
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && eff_active && last) |=> !active_ff)
      else $error("stepper still active after last pixel");

   // input side stalls only behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without cause");

   // a moved item always lands in the result register
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("result lost");

endmodule

### test/line_pixel_stepper_top_tb.sv
// ---------------------------------------------------------------------------
// line_pixel_stepper_top_tb
// self-checking bench for the error-accumulator line stepper: segment
// commands go in on the req channel, and a pixel scoreboard models the
// stepper state to predict each result and compare it on the rsp channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_stepper_top_tb;
   import lps_pkg::*;

   localparam int QuietLimit = 4000;
   localparam int PhaseItems = 175;

   class pixel_scoreboard;
      rsp_item_type  expected_pixels[$];
      int            failures;
      logic          active;
      logic          y_major;
      logic          major_back;
      coord_type     cur_major;
      coord_type     cur_minor;
      coord_type     stop_major;
      minor_dir_type minor_step;
      len_type       major_len;
      len_type       minor_len;
      err_type       error_acc;

      function new();
         failures   = 0;
         active     = 1'b0;
         y_major    = 1'b0;
         major_back = 1'b0;
         cur_major  = '0;
         cur_minor  = '0;
         stop_major = '0;
         minor_step = MINOR_HOLD;
         major_len  = '0;
         minor_len  = '0;
         error_acc  = '0;
      endfunction

      function rsp_item_type next_pixel(req_item_type r);
         rsp_item_type res;
         int           dx;
         int           dy;
         coord_type    minor_from;
         coord_type    minor_to;
         res = '0;
         if (r.op == OP_START) begin
            dx = int'(r.start_x) - int'(r.end_x);
            dy = int'(r.start_y) - int'(r.end_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            active = 1'b0;
            if ((r.start_x < 0 && r.end_x < 0) || (dx == 0 && dy == 0)) return res;
            if (dx > dy) begin
               y_major    = 1'b0;
               cur_major  = r.start_x;
               stop_major = r.end_x;
               major_back = (r.end_x < r.start_x);
               major_len  = len_type'(dx);
               minor_len  = len_type'(dy);
               minor_from = r.start_y;
               minor_to   = r.end_y;
            end else begin
               y_major    = 1'b1;
               cur_major  = r.start_y;
               stop_major = r.end_y;
               major_back = (r.end_y < r.start_y);
               major_len  = len_type'(dy);
               minor_len  = len_type'(dx);
               minor_from = r.start_x;
               minor_to   = r.end_x;
            end
            cur_minor = minor_from;
            if (minor_to > minor_from) minor_step = MINOR_UP;
            else if (minor_to < minor_from) minor_step = MINOR_DOWN;
            else minor_step = MINOR_HOLD;
            error_acc = '0;
            active    = 1'b1;
         end else if (!active) begin
            return res;
         end
         // emit current pixel, then step
         res.pixel_valid = 1'b1;
         res.pixel_x     = y_major ? cur_minor : cur_major;
         res.pixel_y     = y_major ? cur_major : cur_minor;
         error_acc = error_acc + {1'b0, minor_len} + err_type'(1);
         if (error_acc >= {1'b0, major_len} + err_type'(1)) begin
            if (minor_step == MINOR_UP) cur_minor = cur_minor + coord_type'(1);
            else if (minor_step == MINOR_DOWN) cur_minor = cur_minor - coord_type'(1);
            error_acc = error_acc - ({1'b0, major_len} + err_type'(1));
         end
         cur_major = major_back ? cur_major - coord_type'(1) : cur_major + coord_type'(1);
         res.last_pixel = (cur_major == stop_major);
         if (res.last_pixel) active = 1'b0;
         return res;
      endfunction

      function logic note_request(req_item_type r);
         rsp_item_type res;
         res = next_pixel(r);
         expected_pixels.push_back(res);
         return res.pixel_valid;
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp;
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: pixel_valid %0b x %0d y %0d last %0b",
                   got.pixel_valid, got.pixel_x, got.pixel_y, got.last_pixel);
            failures++;
            return;
         end
         exp = expected_pixels.pop_front();
         if (got.pixel_valid !== exp.pixel_valid) begin
            $error("pixel_valid: expected %0b, actual %0b", exp.pixel_valid, got.pixel_valid);
            failures++;
         end
         if (got.pixel_x !== exp.pixel_x) begin
            $error("pixel_x: expected %0d, actual %0d", exp.pixel_x, got.pixel_x);
            failures++;
         end
         if (got.pixel_y !== exp.pixel_y) begin
            $error("pixel_y: expected %0d, actual %0d", exp.pixel_y, got.pixel_y);
            failures++;
         end
         if (got.last_pixel !== exp.last_pixel) begin
            $error("last_pixel: expected %0b, actual %0b", exp.last_pixel, got.last_pixel);
            failures++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   pixel_scoreboard book;
   int              send_idle_pct;
   int              rsp_stall_pct;
   int              drawn_items;
   int              quiet_cycles;

   line_pixel_stepper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side: random stall and result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(rsp_item);
      rsp_stall <= (!reset && rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct);
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type make_req(op_type op, int sx, int sy, int ex, int ey);
      req_item_type r;
      r.op      = op;
      r.start_x = coord_type'(sx);
      r.start_y = coord_type'(sy);
      r.end_x   = coord_type'(ex);
      r.end_y   = coord_type'(ey);
      return r;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int clamp_coord(int v);
      if (v < -2048) return -2048;
      if (v > 2047) return 2047;
      return v;
   endfunction

   task automatic send_item(req_item_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (req_stall);
      void'(book.note_request(r));
      drawn_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   task automatic send_advances(int count);
      repeat (count) send_item(make_req(OP_ADVANCE, rand_coord(), rand_coord(),
                                        rand_coord(), rand_coord()));
   endtask

   task automatic send_segment();
      int pick;
      int sx;
      int sy;
      int ex;
      int ey;
      int span;
      int count;
      pick = $urandom_range(99);
      sy   = rand_coord();
      if (pick < 70) begin
         sx = int'($urandom_range(2067)) - 20;
         ex = clamp_coord(sx + int'($urandom_range(24)) - 12);
         ey = clamp_coord(sy + int'($urandom_range(24)) - 12);
      end else if (pick < 78) begin
         sx = -1 - int'($urandom_range(2047));
         ex = -1 - int'($urandom_range(2047));
         ey = rand_coord();
      end else begin
         sx = rand_coord();
         ex = rand_coord();
         ey = rand_coord();
      end
      span = (sx > ex) ? sx - ex : ex - sx;
      if (sy - ey > span) span = sy - ey;
      if (ey - sy > span) span = ey - sy;
      send_item(make_req(OP_START, sx, sy, ex, ey));
      if (pick >= 70) count = $urandom_range(30);
      else if ($urandom_range(9) == 0) count = $urandom_range(span);
      else count = span - 1 + int'($urandom_range(2));
      if (count > 0) send_advances(count);
   endtask

   task automatic send_directed();
      send_item(make_req(OP_ADVANCE, 0, 0, 0, 0));
      send_item(make_req(OP_START, -2048, -2048, 2047, 2047));
      send_advances(1);
      // new segment while the previous one still runs
      send_item(make_req(OP_START, 2047, -2048, -2048, 2047));
      send_advances(1);
      send_item(make_req(OP_START, 2047, 2047, 2047, 2047));
      send_item(make_req(OP_START, -5, 2047, -1, -2048));
      send_item(make_req(OP_START, -3, 0, 4, 1));
      send_advances(8);
      send_item(make_req(OP_START, 10, 10, 11, 10));
      send_advances(1);
      send_item(make_req(OP_START, 0, 5, 0, 2));
      send_advances(2);
      send_item(make_req(OP_START, 5, 0, 3, 4));
      send_advances(3);
   endtask

   initial begin
      int send_pct[4];
      int stall_pct[4];
      send_pct      = '{0, 52, 0, 20};
      stall_pct     = '{0, 0, 52, 20};
      book          = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drawn_items   = 0;
      quiet_cycles  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         while (drawn_items < PhaseItems * (phase + 1)) send_segment();
         drain_results();
      end
      repeat (10) @(posedge clock);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
src/lps_pkg.sv
src/line_pixel_stepper_top.sv
test/line_pixel_stepper_top_tb.sv
